// ===== src/lecar_pkg.sv =====
// lecar_pkg: shared sizes, command/status structs and the reward factor table
// used by the controller, the datapath and the top level of the replacement core
// no dependencies
`timescale 1ns / 1ps

package lecar_pkg;

  localparam int CACHE_SLOTS = 12;
  localparam int HIST_SLOTS  = 4;
  localparam int PAGE_BITS   = 16;
  localparam int TIME_BITS   = 32;
  localparam int COUNT_BITS  = 16;
  localparam int WGT_BITS    = 16;
  localparam int FAC_BITS    = 17;

  localparam int SLOT_IDX_W = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
  localparam int HIST_IDX_W = (HIST_SLOTS > 1) ? $clog2(HIST_SLOTS) : 1;

  // weight products, their sum and the dividend of the renormalization
  localparam int PROD_BITS = WGT_BITS + FAC_BITS;
  localparam int SUM_BITS  = PROD_BITS + 1;
  localparam int NUM_BITS  = SUM_BITS + WGT_BITS;
  localparam int Q_BITS    = WGT_BITS + 1;

  // one shared step counter drives the divider and the slot/history scans
  localparam int ITERS_A = (Q_BITS > CACHE_SLOTS) ? Q_BITS : CACHE_SLOTS;
  localparam int ITERS   = (ITERS_A > HIST_SLOTS) ? ITERS_A : HIST_SLOTS;
  localparam int CNT_W   = $clog2(ITERS + 1);

  localparam logic [WGT_BITS-1:0]   WEIGHT_HALF = 16'd32768;
  localparam logic [WGT_BITS-1:0]   WEIGHT_MAX  = 16'd65535;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX   = 16'd65535;
  localparam logic [FAC_BITS-1:0]   FAC_ONE     = 17'd65536;

  localparam logic POLICY_RECENCY   = 1'b0;
  localparam logic POLICY_FREQUENCY = 1'b1;

  typedef struct packed {
    logic             load;
    logic             lookup;
    logic             mul;
    logic             sum;
    logic             prep;
    logic             step;
    logic [CNT_W-1:0] cnt;
    logic             finish;
  } lecar_cmd_t;

  typedef struct packed {
    logic miss;
    logic out_free;
  } lecar_sts_t;

  // round(2.718^(0.45*0.64^age) * 65536), age saturated at 31
  function automatic logic [FAC_BITS-1:0] reward_factor(input logic [4:0] age);
    logic [FAC_BITS-1:0] f;
    case (age)
      5'd0:  f = 17'd102776;
      5'd1:  f = 17'd87407;
      5'd2:  f = 17'd78799;
      5'd3:  f = 17'd73740;
      5'd4:  f = 17'd70675;
      5'd5:  f = 17'd68780;
      5'd6:  f = 17'd67594;
      5'd7:  f = 17'd66846;
      5'd8:  f = 17'd66371;
      5'd9:  f = 17'd66069;
      5'd10: f = 17'd65877;
      5'd11: f = 17'd65754;
      5'd12: f = 17'd65675;
      5'd13: f = 17'd65625;
      5'd14: f = 17'd65593;
      5'd15: f = 17'd65573;
      5'd16: f = 17'd65559;
      5'd17: f = 17'd65551;
      5'd18: f = 17'd65546;
      5'd19: f = 17'd65542;
      5'd20: f = 17'd65540;
      5'd21: f = 17'd65539;
      5'd22: f = 17'd65538;
      5'd23: f = 17'd65537;
      5'd24: f = 17'd65537;
      default: f = 17'd65536;
    endcase
    return f;
  endfunction

endpackage

// ===== src/lecar_ctrl.sv =====
// lecar_ctrl: sequencer of one page request (lookup, weight update, scan, commit)
// depends on lecar_pkg
`timescale 1ns / 1ps

module lecar_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  lecar_pkg::lecar_sts_t sts_i,
  output lecar_pkg::lecar_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOOKUP, ST_MUL, ST_SUM, ST_PREP, ST_ITER, ST_FINISH
  } state_e;

  state_e                       state_q;
  logic [lecar_pkg::CNT_W-1:0]  cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE:   if (in_valid_i) state_q <= ST_LOOKUP;
        ST_LOOKUP: state_q <= sts_i.miss ? ST_MUL : ST_FINISH;
        ST_MUL:    state_q <= ST_SUM;
        ST_SUM:    state_q <= ST_PREP;
        ST_PREP: begin
          state_q <= ST_ITER;
          cnt_q   <= '0;
        end
        ST_ITER: begin
          if (cnt_q == lecar_pkg::CNT_W'(lecar_pkg::ITERS - 1)) begin
            state_q <= ST_FINISH;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_FINISH: if (sts_i.out_free) state_q <= ST_IDLE;
        default:   state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.lookup = (state_q == ST_LOOKUP);
    cmd_o.mul    = (state_q == ST_MUL);
    cmd_o.sum    = (state_q == ST_SUM);
    cmd_o.prep   = (state_q == ST_PREP);
    cmd_o.step   = (state_q == ST_ITER);
    cmd_o.cnt    = cnt_q;
    cmd_o.finish = (state_q == ST_FINISH) && sts_i.out_free;
  end

  // scan counter never runs past the last step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ITER) |-> (cnt_q < lecar_pkg::CNT_W'(lecar_pkg::ITERS)))
    else $error("step counter out of range");
  // a hit or a zero page goes straight to commit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOKUP && !sts_i.miss) |=> (state_q == ST_FINISH))
    else $error("non-miss did not go to commit");
  // a miss always walks the weight update
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOKUP && sts_i.miss) |=> (state_q == ST_MUL))
    else $error("miss skipped weight update");

endmodule

// ===== src/lecar_dp.sv =====
// lecar_dp: cache slots, eviction histories, weight, divider and victim scans
// depends on lecar_pkg; driven by lecar_ctrl commands
`timescale 1ns / 1ps

module lecar_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lecar_pkg::lecar_cmd_t             cmd_i,
  output lecar_pkg::lecar_sts_t             sts_o,
  input  logic [lecar_pkg::PAGE_BITS-1:0]   in_page_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic                              out_hit_o,
  output logic                              out_evicted_o,
  output logic [lecar_pkg::PAGE_BITS-1:0]   out_ev_page_o,
  output logic                              out_policy_o,
  output logic [lecar_pkg::WGT_BITS-1:0]    out_weight_o
);

  localparam int NS = lecar_pkg::CACHE_SLOTS;
  localparam int NH = lecar_pkg::HIST_SLOTS;
  localparam int PB = lecar_pkg::PAGE_BITS;
  localparam int TB = lecar_pkg::TIME_BITS;
  localparam int CB = lecar_pkg::COUNT_BITS;
  localparam int WB = lecar_pkg::WGT_BITS;
  localparam int SI = lecar_pkg::SLOT_IDX_W;
  localparam int HI = lecar_pkg::HIST_IDX_W;
  localparam int QB = lecar_pkg::Q_BITS;
  localparam int SB = lecar_pkg::SUM_BITS;
  localparam int NB = lecar_pkg::NUM_BITS;

  logic [PB-1:0] slot_page_q [NS];
  logic [TB-1:0] slot_time_q [NS];
  logic [CB-1:0] slot_cnt_q  [NS];
  logic [PB-1:0] rh_page_q   [NH];
  logic [TB-1:0] rh_time_q   [NH];
  logic [PB-1:0] fh_page_q   [NH];
  logic [TB-1:0] fh_time_q   [NH];
  logic [WB-1:0] weight_q;
  logic [TB-1:0] now_q;

  logic [PB-1:0] page_q;
  logic          zero_q, hit_q, empty_any_q, rew_rec_q;
  logic [SI-1:0] hit_idx_q, empty_idx_q;
  logic [lecar_pkg::FAC_BITS-1:0] fac_q;
  logic [SB-1:0] wa_q, wb_q, sum_q, rem_q;
  logic [QB-1:0] nlow_q, quo_q;
  logic [SI-1:0] lru_idx_q, lfu_idx_q;
  logic [TB-1:0] lru_age_q;
  logic [CB-1:0] lfu_cnt_q;
  logic [HI-1:0] rh_old_idx_q, fh_old_idx_q;
  logic [TB-1:0] rh_old_age_q, fh_old_age_q;

  logic          out_valid_q, out_hit_q, out_ev_q, out_pol_q;
  logic [PB-1:0] out_page_q;
  logic [WB-1:0] out_weight_q;

  // parallel lookups
  logic          hit_any, empty_any, rh_any, fh_any, rh_empty_any, fh_empty_any;
  logic [SI-1:0] hit_idx, empty_idx;
  logic [HI-1:0] rh_idx, fh_idx, rh_empty_idx, fh_empty_idx;

  always_comb begin
    hit_any = 1'b0; empty_any = 1'b0; hit_idx = '0; empty_idx = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (slot_page_q[i] == page_q) begin
        hit_any = 1'b1; hit_idx = SI'(i);
      end
      if (slot_page_q[i] == '0) begin
        empty_any = 1'b1; empty_idx = SI'(i);
      end
    end
    rh_any = 1'b0; fh_any = 1'b0; rh_idx = '0; fh_idx = '0;
    rh_empty_any = 1'b0; fh_empty_any = 1'b0; rh_empty_idx = '0; fh_empty_idx = '0;
    for (int j = NH - 1; j >= 0; j--) begin
      if (rh_page_q[j] == page_q) begin
        rh_any = 1'b1; rh_idx = HI'(j);
      end
      if (fh_page_q[j] == page_q) begin
        fh_any = 1'b1; fh_idx = HI'(j);
      end
      if (rh_page_q[j] == '0) begin
        rh_empty_any = 1'b1; rh_empty_idx = HI'(j);
      end
      if (fh_page_q[j] == '0) begin
        fh_empty_any = 1'b1; fh_empty_idx = HI'(j);
      end
    end
  end

  // reward age from the deciding history, saturated at 31
  logic [TB-1:0] rew_age;
  logic [4:0]    rew_age_sat;
  always_comb begin
    rew_age     = now_q - (rh_any ? rh_time_q[rh_idx] : fh_time_q[fh_idx]);
    rew_age_sat = (|rew_age[TB-1:5]) ? 5'd31 : rew_age[4:0];
  end

  // weights: a recency, b = 1 - a
  logic [WB:0]   b_w;
  logic [SB-1:0] prod;
  assign b_w  = 17'd65536 - {1'b0, weight_q};
  assign prod = SB'(rew_rec_q ? b_w : {1'b0, weight_q}) * SB'(fac_q);

  // divider step and scan values
  logic [SB:0]   r2;
  logic [NB-1:0] numer;
  logic [SI-1:0] scan_s;
  logic [HI-1:0] scan_h;
  logic [TB-1:0] scan_age, rh_scan_age, fh_scan_age;
  assign r2     = {rem_q, nlow_q[QB-1]};
  assign numer  = {wa_q, 16'b0} + NB'(sum_q >> 1);
  assign scan_s = cmd_i.cnt[SI-1:0];
  assign scan_h = cmd_i.cnt[HI-1:0];
  assign scan_age    = now_q - slot_time_q[scan_s];
  assign rh_scan_age = now_q - rh_time_q[scan_h];
  assign fh_scan_age = now_q - fh_time_q[scan_h];

  // commit decisions
  logic [WB-1:0] w_new;
  logic          pol;
  logic [SI-1:0] victim;
  logic [HI-1:0] ins_idx;
  assign w_new   = quo_q[QB-1] ? lecar_pkg::WEIGHT_MAX : quo_q[WB-1:0];
  assign pol     = (w_new > lecar_pkg::WEIGHT_HALF) ? lecar_pkg::POLICY_RECENCY
                                                   : lecar_pkg::POLICY_FREQUENCY;
  assign victim  = (pol == lecar_pkg::POLICY_RECENCY) ? lru_idx_q : lfu_idx_q;
  assign ins_idx = (pol == lecar_pkg::POLICY_RECENCY)
                 ? (rh_empty_any ? rh_empty_idx : rh_old_idx_q)
                 : (fh_empty_any ? fh_empty_idx : fh_old_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NS; i++) begin
        slot_page_q[i] <= '0; slot_time_q[i] <= '0; slot_cnt_q[i] <= '0;
      end
      for (int j = 0; j < NH; j++) begin
        rh_page_q[j] <= '0; rh_time_q[j] <= '0;
        fh_page_q[j] <= '0; fh_time_q[j] <= '0;
      end
      weight_q    <= lecar_pkg::WEIGHT_HALF;
      now_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.finish) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;

      if (cmd_i.load && (in_page_i != '0)) now_q <= now_q + 1'b1;

      if (cmd_i.lookup && !zero_q && !hit_any) begin
        for (int j = 0; j < NH; j++) begin
          if (rh_page_q[j] == page_q) rh_page_q[j] <= '0;
          if (fh_page_q[j] == page_q) fh_page_q[j] <= '0;
        end
      end

      if (cmd_i.finish) begin
        if (hit_q) begin
          if (slot_cnt_q[hit_idx_q] != lecar_pkg::COUNT_MAX)
            slot_cnt_q[hit_idx_q] <= slot_cnt_q[hit_idx_q] + 1'b1;
          slot_time_q[hit_idx_q] <= now_q;
        end else if (!zero_q) begin
          weight_q <= w_new;
          if (empty_any_q) begin
            slot_page_q[empty_idx_q] <= page_q;
            slot_time_q[empty_idx_q] <= now_q;
            slot_cnt_q[empty_idx_q]  <= CB'(1);
          end else begin
            slot_page_q[victim] <= page_q;
            slot_time_q[victim] <= now_q;
            slot_cnt_q[victim]  <= CB'(1);
            if (pol == lecar_pkg::POLICY_RECENCY) begin
              rh_page_q[ins_idx] <= slot_page_q[victim];
              rh_time_q[ins_idx] <= now_q;
            end else begin
              fh_page_q[ins_idx] <= slot_page_q[victim];
              fh_time_q[ins_idx] <= now_q;
            end
          end
        end
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) page_q <= in_page_i;
    if (cmd_i.lookup) begin
      zero_q      <= (page_q == '0);
      hit_q       <= (page_q != '0) && hit_any;
      hit_idx_q   <= hit_idx;
      empty_any_q <= empty_any;
      empty_idx_q <= empty_idx;
      rew_rec_q   <= rh_any;
      fac_q       <= (rh_any || fh_any) ? lecar_pkg::reward_factor(rew_age_sat)
                                        : lecar_pkg::FAC_ONE;
    end
    if (cmd_i.mul) begin
      wa_q <= rew_rec_q ? SB'({weight_q, 16'b0}) : prod;
      wb_q <= rew_rec_q ? prod : SB'({b_w, 16'b0});
    end
    if (cmd_i.sum) sum_q <= wa_q + wb_q;
    if (cmd_i.prep) begin
      rem_q  <= SB'(numer[NB-1:QB]);
      nlow_q <= numer[QB-1:0];
      quo_q  <= '0;
    end
    if (cmd_i.step) begin
      if (cmd_i.cnt < lecar_pkg::CNT_W'(QB)) begin
        nlow_q <= {nlow_q[QB-2:0], 1'b0};
        if (r2 >= {1'b0, sum_q}) begin
          rem_q <= SB'(r2 - {1'b0, sum_q});
          quo_q <= {quo_q[QB-2:0], 1'b1};
        end else begin
          rem_q <= r2[SB-1:0];
          quo_q <= {quo_q[QB-2:0], 1'b0};
        end
      end
      if (cmd_i.cnt < lecar_pkg::CNT_W'(NS)) begin
        if (cmd_i.cnt == '0 || scan_age > lru_age_q) begin
          lru_age_q <= scan_age; lru_idx_q <= scan_s;
        end
        if (cmd_i.cnt == '0 || slot_cnt_q[scan_s] < lfu_cnt_q) begin
          lfu_cnt_q <= slot_cnt_q[scan_s]; lfu_idx_q <= scan_s;
        end
      end
      if (cmd_i.cnt < lecar_pkg::CNT_W'(NH)) begin
        if (cmd_i.cnt == '0 || rh_scan_age > rh_old_age_q) begin
          rh_old_age_q <= rh_scan_age; rh_old_idx_q <= scan_h;
        end
        if (cmd_i.cnt == '0 || fh_scan_age > fh_old_age_q) begin
          fh_old_age_q <= fh_scan_age; fh_old_idx_q <= scan_h;
        end
      end
    end
    if (cmd_i.finish) begin
      out_hit_q <= hit_q;
      out_ev_q  <= !hit_q && !zero_q && !empty_any_q;
      if (!hit_q && !zero_q && !empty_any_q) begin
        out_page_q <= slot_page_q[victim];
        out_pol_q  <= pol;
      end else begin
        out_page_q <= '0;
        out_pol_q  <= lecar_pkg::POLICY_RECENCY;
      end
      out_weight_q <= (!hit_q && !zero_q) ? w_new : weight_q;
    end
  end

  assign sts_o.miss     = (page_q != '0) && !hit_any;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign out_hit_o     = out_hit_q;
  assign out_evicted_o = out_ev_q;
  assign out_ev_page_o = out_page_q;
  assign out_policy_o  = out_pol_q;
  assign out_weight_o  = out_weight_q;

endmodule

// ===== src/lecar_adaptive_replacement_core.sv =====
// lecar_adaptive_replacement_core: top level of the adaptive lru/lfu page cache
// instantiates lecar_ctrl and lecar_dp; depends on lecar_pkg
// steps: a hit or zero page goes from lookup to commit; a miss runs lookup, multiply,
//   sum, dividend and a 17-step divider that also scans slots and histories one entry
//   a cycle, then commit
// one item at a time: the next page is accepted only after the last result is committed
// reset: async active low; slots and histories empty, weight one half, time zero
`timescale 1ns / 1ps

module lecar_adaptive_replacement_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] page_id
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [0] hit, [1] evicted, [17:2] evicted_page,
                                      // [18] policy_used, [34:19] recency_weight, zero pad
);

  lecar_pkg::lecar_cmd_t cmd;
  lecar_pkg::lecar_sts_t sts;

  logic        o_hit, o_ev, o_pol;
  logic [15:0] o_page, o_weight;

  // sequencer: one request in flight, output register frees it from the consumer
  lecar_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // state, weight arithmetic and victim selection
  lecar_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_page_i     (s_axis_tdata[lecar_pkg::PAGE_BITS-1:0]),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_hit_o     (o_hit),
    .out_evicted_o (o_ev),
    .out_ev_page_o (o_page),
    .out_policy_o  (o_pol),
    .out_weight_o  (o_weight)
  );

  // result item packing, lowest field first
  assign m_axis_tdata = {5'b0, o_weight, o_pol, o_page, o_ev, o_hit};

  // a hit never evicts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("hit reported with eviction");
  // no eviction means empty page field and recency policy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[1]) |-> (m_axis_tdata[18:2] == 17'd0))
    else $error("eviction fields set without eviction");
  // one request at a time: accept drops ready for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second item taken while busy");

endmodule
